// File: rtl/core/bgf_pkg.sv
// Package: shared types, constants and the command struct for the gap filler.
`default_nettype none
package bgf_pkg;
  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned CoordW    = $clog2(MaxWidth + 1);
  localparam int unsigned RowW      = $clog2(MaxHeight + 1);
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned PosW      = $clog2(Depth + 1);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [CfgIdxW-1:0] RegPolarity = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGapW     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGapH     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd4;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_out;
  } out_item_t;

  // Controller to datapath: at most one memory operation per cycle.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/bgf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bgf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] addr_i,
  input  wire  [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/bgf_datapath.sv
// Datapath: frame memory and its read data path.
`default_nettype none
module bgf_datapath import bgf_pkg::*; (
  input  wire        clk_i,
  input  mem_cmd_t   cmd_i,
  output logic [7:0] rdata_o
);
  bgf_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .addr_i (cmd_i.addr),
    .wdata_i(cmd_i.wdata),
    .rdata_o(rdata_o)
  );
endmodule
`default_nettype wire

// File: rtl/core/bgf_ctrl.sv
// Controller: load, scan sequencer and readout state machine.
`default_nettype none
module bgf_ctrl import bgf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output out_item_t        out_data_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [CfgIdxW-1:0]  cfg_index_i,
  input  wire [CfgDataW-1:0] cfg_data_i,
  output mem_cmd_t         cmd_o,
  input  wire [7:0]        rdata_i
);
  typedef enum logic [3:0] {
    StIdle, StSeedRd, StSeedChk, StNbrChk, StHLook, StHFill,
    StVNbrChk, StVLook, StVFill, StNext, StRdWait, StRdOut
  } state_e;

  state_e state_q;
  logic       pol_q;
  logic [9:0] gapw_q, gaph_q, fw_q, fh_q;
  logic [PosW-1:0] load_q, rdpos_q;
  logic            done_q;
  logic [CoordW-1:0] col_q;   // seed column j
  logic [RowW-1:0]   row_q;   // seed row i
  logic [CoordW:0]   k_q;     // look-ahead position along the line
  logic [CoordW:0]   hit_q;   // end of fill (exclusive)
  logic [CoordW:0]   last_q;
  logic              vert_q;  // current line is vertical
  mem_cmd_t          cmd_q;

  logic [CoordW-1:0] w;
  logic [RowW-1:0]   h;
  logic [PosW-1:0]   size;
  logic [7:0]        fill, other;

  always_comb begin
    w = (fw_q == '0) ? CoordW'(1) : ((fw_q > 10'(MaxWidth)) ? CoordW'(MaxWidth) : CoordW'(fw_q));
    h = (fh_q == '0) ? RowW'(1) : ((fh_q > 10'(MaxHeight)) ? RowW'(MaxHeight) : RowW'(fh_q));
    fill  = pol_q ? 8'd0 : 8'd255;
    other = ~fill;
  end

  // Frame size in pixels.
  assign size = PosW'(w) * PosW'(h);

  // Address of line element k: horizontal is row*w+k, vertical is k*w+col.
  function automatic logic [AddrW-1:0] pix(input logic [RowW:0] r, input logic [CoordW:0] c,
                                           input logic [CoordW-1:0] wd);
    return AddrW'(r) * AddrW'(wd) + AddrW'(c);
  endfunction

  logic [AddrW-1:0] line_addr;
  always_comb begin
    if (vert_q) line_addr = pix((RowW+1)'(k_q), (CoordW+1)'(col_q), w);
    else        line_addr = pix((RowW+1)'(row_q), k_q, w);
  end

  // Line length, seed position and limit for the current line.
  logic [CoordW:0] cnt, pos;
  logic [10:0]     lim;
  always_comb begin
    cnt = vert_q ? (CoordW+1)'(h) : (CoordW+1)'(w);
    pos = vert_q ? (CoordW+1)'(row_q) : (CoordW+1)'(col_q);
    lim = vert_q ? 11'(gaph_q) : 11'(gapw_q);
  end

  logic [11:0] plim, lastv;
  always_comb begin
    plim  = 12'(pos) + 12'(lim);
    lastv = plim + 12'd1;
    if (lastv < 12'(pos) + 12'd2) lastv = 12'(pos) + 12'd2;
    if (lastv > 12'(cnt) - 12'd1) lastv = 12'(cnt) - 12'd1;
  end

  assign in_stall_o  = (state_q != StIdle) || out_valid_o || cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_o;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pol_q <= 1'b1; gapw_q <= 10'd20; gaph_q <= 10'd20;
      fw_q <= 10'd512; fh_q <= 10'd512;
      load_q <= '0; rdpos_q <= '0; done_q <= 1'b0;
      out_valid_o <= 1'b0; cmd_q <= '0;
      col_q <= '0; row_q <= '0; k_q <= '0; hit_q <= '0; last_q <= '0; vert_q <= 1'b0;
      out_data_o <= '0;
    end else begin
      cmd_q.rd <= 1'b0;
      cmd_q.wr <= 1'b0;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cfg_valid_i && cfg_ready_o) begin
            unique case (cfg_index_i)
              RegPolarity: pol_q  <= cfg_data_i[0];
              RegGapW:     gapw_q <= cfg_data_i;
              RegGapH:     gaph_q <= cfg_data_i;
              RegWidth:  begin fw_q <= cfg_data_i; load_q <= '0; rdpos_q <= '0; done_q <= 1'b0; end
              RegHeight: begin fh_q <= cfg_data_i; load_q <= '0; rdpos_q <= '0; done_q <= 1'b0; end
              default: ;
            endcase
          end else if (in_valid_i && !in_stall_o) begin
            if (!in_data_i.mode) begin
              // Load one pixel; wrap positions past the frame end.
              cmd_q.wr    <= 1'b1;
              cmd_q.addr  <= AddrW'((load_q >= size) ? '0 : load_q);
              cmd_q.wdata <= in_data_i.pixel_in;
              load_q  <= ((load_q >= size) || (load_q + 1'b1 >= size)) ? '0 : load_q + 1'b1;
              rdpos_q <= '0;
              done_q  <= 1'b0;
            end else begin
              if (rdpos_q >= size) rdpos_q <= '0;
              if (load_q >= size) load_q <= '0;
              if (!done_q && w > 1 && h > 1) begin
                row_q <= '0; col_q <= '0;
                state_q <= StSeedRd;
              end else begin
                done_q <= 1'b1;
                state_q <= StRdWait;
                cmd_q.rd <= 1'b1;
                cmd_q.addr <= AddrW'((rdpos_q >= size) ? '0 : rdpos_q);
              end
            end
          end
        end
        StSeedRd: begin
          cmd_q.rd <= 1'b1;
          cmd_q.addr <= pix((RowW+1)'(row_q), (CoordW+1)'(col_q), w);
          state_q <= StSeedChk;
        end
        StSeedChk: begin
          // Wait cycle; also request right neighbor.
          cmd_q.rd <= 1'b1;
          cmd_q.addr <= pix((RowW+1)'(row_q), (CoordW+1)'(col_q) + 1'b1, w);
          state_q <= StNbrChk;
        end
        StNbrChk: begin
          if (rdata_i != fill) state_q <= StNext;
          else begin
            state_q <= StHLook;
            vert_q  <= 1'b0;
            k_q     <= '0;
          end
        end
        StHLook, StVLook: begin
          // k_q==0: neighbor test pending; issue neighbor read first.
          if (k_q == '0) begin
            cmd_q.rd <= 1'b1;
            cmd_q.addr <= vert_q ? pix((RowW+1)'(row_q) + 1'b1, (CoordW+1)'(col_q), w)
                                 : pix((RowW+1)'(row_q), (CoordW+1)'(col_q) + 1'b1, w);
            k_q <= (CoordW+1)'(1);
            hit_q <= '0;
          end else if (k_q == (CoordW+1)'(1)) begin
            k_q <= (CoordW+1)'(2);  // read latency
          end else if (k_q == (CoordW+1)'(2)) begin
            if (rdata_i != other) state_q <= vert_q ? StNext : StVNbrChk;
            else if (plim >= 12'(cnt)) begin
              hit_q <= cnt;
              k_q <= pos + 1'b1;
              state_q <= vert_q ? StVFill : StHFill;
            end else begin
              last_q <= (CoordW+1)'(lastv);
              k_q <= pos + 2'd2;
              hit_q <= '1;  // marks search phase
              cmd_q.rd <= 1'b1;
              cmd_q.addr <= vert_q ? pix((RowW+1)'(pos) + 2'd2, (CoordW+1)'(col_q), w)
                                   : pix((RowW+1)'(row_q), pos + 2'd2, w);
              state_q <= vert_q ? StVFill : StHFill;
              vert_q <= vert_q;
            end
          end
        end
        StHFill, StVFill: begin
          if (hit_q == '1) begin
            // Search: one read in flight; evaluate it once its data is back (command register, then RAM read register).
            // A position past the search window never matches.
            if (!cmd_q.rd) begin
              if ((k_q <= last_q) && (rdata_i == fill)) begin
                hit_q <= k_q;
                k_q <= pos + 1'b1;
              end else if (k_q >= last_q) begin
                state_q <= vert_q ? StNext : StVNbrChk;
              end else begin
                k_q <= k_q + 1'b1;
                cmd_q.rd <= 1'b1;
                cmd_q.addr <= vert_q ? pix((RowW+1)'(k_q + 1'b1), (CoordW+1)'(col_q), w)
                                     : pix((RowW+1)'(row_q), k_q + 1'b1, w);
              end
            end
          end else if (k_q < hit_q) begin
            cmd_q.wr <= 1'b1;
            cmd_q.wdata <= fill;
            cmd_q.addr <= line_addr;
            k_q <= k_q + 1'b1;
          end else state_q <= vert_q ? StNext : StVNbrChk;
        end
        StVNbrChk: begin
          vert_q <= 1'b1;
          k_q <= '0;
          state_q <= StVLook;
        end
        StNext: begin
          vert_q <= 1'b0;
          if ((CoordW+1)'(col_q) + 2'd2 < (CoordW+1)'(w)) begin
            col_q <= col_q + 1'b1;
            state_q <= StSeedRd;
          end else if ((RowW+1)'(row_q) + 2'd2 < (RowW+1)'(h)) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
            state_q <= StSeedRd;
          end else begin
            done_q <= 1'b1;
            cmd_q.rd <= 1'b1;
            cmd_q.addr <= AddrW'(rdpos_q);
            state_q <= StRdWait;
          end
        end
        StRdWait: state_q <= StRdOut;
        StRdOut: begin
          out_valid_o <= 1'b1;
          out_data_o.pixel_out <= rdata_i;
          out_data_o.last_out  <= (rdpos_q + 1'b1 >= size);
          rdpos_q <= (rdpos_q + 1'b1 >= size) ? '0 : rdpos_q + 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_out_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StRdOut)) else $error("stray result");
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_q.rd && cmd_q.wr)) else $error("read and write together");
`endif
endmodule
`default_nettype wire

// File: rtl/core/binary_gap_filler.sv
// Top level of the binary gap filler.
// Pixels load one per transfer in raster order (mode 0, no result); the first
// read (mode 1) after a load scans the frame in place from the frame memory
// and then returns one pixel per read. A read after the scan runs through
// request, registered memory read, result register and result transfer, and
// the next transfer waits until the result has been taken. The scan runs
// through the single memory port with registered read: a seed that is not
// the fill value is skipped after its read; a fill seed gets a horizontal and
// a vertical neighbor test, one read per looked-ahead pixel and one write per
// filled pixel. Configuration writes are taken only while idle; the input is
// stalled while a configuration write is offered.
`default_nettype none
module binary_gap_filler import bgf_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_item_t  out_data_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [CfgIdxW-1:0]  cfg_index_i,
  input  wire [CfgDataW-1:0] cfg_data_i
);
  mem_cmd_t   cmd;
  logic [7:0] rdata;

  bgf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cmd_o(cmd), .rdata_i(rdata)
  );

  bgf_datapath u_dp (.clk_i, .cmd_i(cmd), .rdata_o(rdata));
endmodule
`default_nettype wire
